// ----- rtl/kmpq_pkg.sv -----
// Shared types and constants for the keyed max priority queue.
package kmpq_pkg;

    localparam int CAPACITY = 32;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int KEY_W    = 16;
    localparam int SCORE_W  = 32;

    localparam logic [2:0] MODE_INSERT = 3'd0;
    localparam logic [2:0] MODE_REMOVE = 3'd1;
    localparam logic [2:0] MODE_ADD    = 3'd2;
    localparam logic [2:0] MODE_TOP    = 3'd3;
    localparam logic [2:0] MODE_LIST   = 3'd4;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_DUP      = 3'd1;
    localparam logic [2:0] ST_NOTFOUND = 3'd2;
    localparam logic [2:0] ST_EMPTY    = 3'd3;
    localparam logic [2:0] ST_FULL     = 3'd4;

    typedef struct packed {
        logic [2:0]                mode;
        logic [KEY_W-1:0]          entry_key;
        logic signed [SCORE_W-1:0] score_value;
    } t_in_req;

    typedef struct packed {
        logic [2:0]                status;
        logic [KEY_W-1:0]          result_key;
        logic signed [SCORE_W-1:0] result_score;
        logic                      last_of_run;
    } t_out_req;

    typedef struct packed {
        logic [KEY_W-1:0]          key;
        logic signed [SCORE_W-1:0] score;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

endpackage

// ----- rtl/kmpq_ram.sv -----
// Generic simple dual-port RAM with registered read.
module kmpq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/kmpq_cmp.sv -----
// Ordering compare: higher score first, equal scores by ascending key.
module kmpq_cmp (
    input  kmpq_pkg::t_entry i_a,
    input  kmpq_pkg::t_entry i_b,
    output logic             o_precedes
);

    always_comb begin
        if (i_a.score != i_b.score) begin
            o_precedes = (i_a.score > i_b.score);
        end else begin
            o_precedes = (i_a.key < i_b.key);
        end
    end

endmodule

// ----- rtl/keyed_max_priority_queue_unit.sv -----
// Top level of the keyed max priority queue: sequencer, entry store and output register.
// Each request is taken only while the sequencer is idle; entries live in a RAM that is
// scanned one entry at a time, a read state then a check state, through a single ordering
// comparator. For N stored entries, list emits N results in order by one selection scan
// per result, and each candidate entry passes through one more compare state.
// A finished result waits in an output register while the next request is accepted.
module keyed_max_priority_queue_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  kmpq_pkg::t_in_req  i_in_req,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output kmpq_pkg::t_out_req o_out_req
);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_RD   = 7'b0000010,
        S_CHK  = 7'b0000100,
        S_CHK2 = 7'b0001000,
        S_FIN  = 7'b0010000,
        S_MV   = 7'b0100000,
        S_EMIT = 7'b1000000
    } t_state;

    t_state r_state, n_state;
    logic [kmpq_pkg::CNT_W-1:0] r_cnt, n_cnt, r_nlist, n_nlist;
    logic [kmpq_pkg::IDX_W-1:0] r_idx, n_idx, r_pos, n_pos;
    logic r_found, n_found, r_has_best, n_has_best;
    kmpq_pkg::t_in_req r_req, n_req;
    kmpq_pkg::t_entry  r_best, n_best, r_prev, n_prev;
    kmpq_pkg::t_out_req r_res, n_res, r_out, n_out;
    logic r_out_valid, n_out_valid;

    logic ram_we;
    logic [kmpq_pkg::IDX_W-1:0] ram_waddr, ram_raddr;
    kmpq_pkg::t_entry ram_wdata, cur;
    logic [kmpq_pkg::ENTRY_W-1:0] ram_rdata;
    kmpq_pkg::t_entry cmp_a, cmp_b;
    logic cmp_out;
    logic signed [kmpq_pkg::SCORE_W:0] sum;
    logic [kmpq_pkg::CNT_W-1:0] cnt_m1;
    logic scan_last;

    kmpq_ram #(
        .WIDTH(kmpq_pkg::ENTRY_W),
        .DEPTH(kmpq_pkg::CAPACITY)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    assign cur = kmpq_pkg::t_entry'(ram_rdata);

    kmpq_cmp u_cmp (
        .i_a       (cmp_a),
        .i_b       (cmp_b),
        .o_precedes(cmp_out)
    );

    assign cnt_m1    = r_cnt - 1'b1;
    assign scan_last = ({1'b0, r_idx} == cnt_m1);
    assign sum = {cur.score[kmpq_pkg::SCORE_W-1], cur.score}
               + {r_req.score_value[kmpq_pkg::SCORE_W-1], r_req.score_value};

    always_comb begin
        // list: first check against the previous result, then against the best so far
        if (r_state == S_CHK && r_req.mode == kmpq_pkg::MODE_LIST) begin
            cmp_a = r_prev;
            cmp_b = cur;
        end else begin
            cmp_a = cur;
            cmp_b = r_best;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_nlist     = r_nlist;
        n_idx       = r_idx;
        n_pos       = r_pos;
        n_found     = r_found;
        n_has_best  = r_has_best;
        n_req       = r_req;
        n_best      = r_best;
        n_prev      = r_prev;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        ram_we      = 1'b0;
        ram_waddr   = r_pos;
        ram_wdata   = cur;
        ram_raddr   = r_idx;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_req      = i_in_req;
                    n_idx      = '0;
                    n_found    = 1'b0;
                    n_has_best = 1'b0;
                    n_nlist    = '0;
                    n_res      = '0;
                    n_res.last_of_run = 1'b1;
                    if (i_in_req.mode > kmpq_pkg::MODE_LIST) begin
                        n_state = S_IDLE;
                    end else if (r_cnt == '0) begin
                        if (i_in_req.mode == kmpq_pkg::MODE_INSERT) begin
                            n_state = S_FIN;
                        end else begin
                            n_res.status = kmpq_pkg::ST_EMPTY;
                            n_state      = S_EMIT;
                        end
                    end else begin
                        n_state = S_RD;
                    end
                end
            end
            S_RD: begin
                n_state = S_CHK;
            end
            S_CHK, S_CHK2: begin
                logic advance;
                advance = 1'b1;
                priority if (r_req.mode == kmpq_pkg::MODE_TOP || r_state == S_CHK2) begin
                    if (!r_has_best || cmp_out) begin
                        n_best     = cur;
                        n_has_best = 1'b1;
                    end
                end else if (r_req.mode == kmpq_pkg::MODE_LIST) begin
                    if (r_nlist == '0 || cmp_out) begin
                        n_state = S_CHK2;
                        advance = 1'b0;
                    end
                end else if (cur.key == r_req.entry_key) begin
                    n_found = 1'b1;
                    n_pos   = r_idx;
                    n_state = S_FIN;
                    advance = 1'b0;
                end else begin
                    // key differs: keep scanning
                    n_found = r_found;
                end
                if (advance) begin
                    if (scan_last) begin
                        n_state = S_FIN;
                    end else begin
                        n_idx   = r_idx + 1'b1;
                        n_state = S_RD;
                    end
                end
            end
            S_FIN: begin
                n_state = S_EMIT;
                unique case (r_req.mode)
                    kmpq_pkg::MODE_INSERT: begin
                        if (r_found) begin
                            n_res.status = kmpq_pkg::ST_DUP;
                        end else if (r_cnt >= kmpq_pkg::CNT_W'(kmpq_pkg::CAPACITY)) begin
                            n_res.status = kmpq_pkg::ST_FULL;
                        end else begin
                            ram_we    = 1'b1;
                            ram_waddr = r_cnt[kmpq_pkg::IDX_W-1:0];
                            ram_wdata = {r_req.entry_key, r_req.score_value};
                            n_cnt     = r_cnt + 1'b1;
                        end
                    end
                    kmpq_pkg::MODE_REMOVE: begin
                        if (!r_found) begin
                            n_res.status = kmpq_pkg::ST_NOTFOUND;
                        end else begin
                            // fetch the last entry to fill the hole
                            ram_raddr = cnt_m1[kmpq_pkg::IDX_W-1:0];
                            n_state   = S_MV;
                        end
                    end
                    kmpq_pkg::MODE_ADD: begin
                        if (!r_found) begin
                            n_res.status = kmpq_pkg::ST_NOTFOUND;
                        end else begin
                            ram_we = 1'b1;
                            ram_wdata.key = cur.key;
                            if (sum[kmpq_pkg::SCORE_W] != sum[kmpq_pkg::SCORE_W-1]) begin
                                ram_wdata.score = sum[kmpq_pkg::SCORE_W]
                                    ? {1'b1, {(kmpq_pkg::SCORE_W-1){1'b0}}}
                                    : {1'b0, {(kmpq_pkg::SCORE_W-1){1'b1}}};
                            end else begin
                                ram_wdata.score = sum[kmpq_pkg::SCORE_W-1:0];
                            end
                        end
                    end
                    default: begin
                        n_res.result_key   = r_best.key;
                        n_res.result_score = r_best.score;
                        n_res.last_of_run  = (r_req.mode == kmpq_pkg::MODE_TOP)
                                          || (r_nlist == cnt_m1);
                    end
                endcase
            end
            S_MV: begin
                ram_we  = 1'b1;
                n_cnt   = cnt_m1;
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    if (r_res.last_of_run) begin
                        n_state = S_IDLE;
                    end else begin
                        // advance to the next rank of the listing
                        n_prev     = r_best;
                        n_nlist    = r_nlist + 1'b1;
                        n_has_best = 1'b0;
                        n_idx      = '0;
                        n_state    = S_RD;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
        r_nlist    <= n_nlist;
        r_idx      <= n_idx;
        r_pos      <= n_pos;
        r_found    <= n_found;
        r_has_best <= n_has_best;
        r_req      <= n_req;
        r_best     <= n_best;
        r_prev     <= n_prev;
        r_res      <= n_res;
        r_out      <= n_out;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_req   = r_out;

endmodule

// ----- test/keyed_max_priority_queue_unit_tb.sv -----
// Testbench for the keyed max priority queue: directed and random requests against a scoreboard.
module keyed_max_priority_queue_unit_tb;

    localparam int LIMIT_CYCLES = 2000000;

    // Model of the store plus queue of expected results
    class queue_scoreboard;
        logic [kmpq_pkg::KEY_W-1:0] keys[kmpq_pkg::CAPACITY];
        longint                     scores[kmpq_pkg::CAPACITY];
        int                         count;
        kmpq_pkg::t_out_req         pending[$];
        int                         mismatches;

        function new();
            count = 0;
            mismatches = 0;
        endfunction

        function int find_key(logic [kmpq_pkg::KEY_W-1:0] k);
            for (int i = 0; i < count; i++) begin
                if (keys[i] == k) return i;
            end
            return -1;
        endfunction

        function bit ahead_of(int a, int b);
            if (scores[a] != scores[b]) return scores[a] > scores[b];
            return keys[a] < keys[b];
        endfunction

        function void add_expected(kmpq_pkg::t_out_req r);
            pending = {pending, r};
        endfunction

        function void push_status(logic [2:0] st);
            kmpq_pkg::t_out_req r;
            r = '0;
            r.status = st;
            r.last_of_run = 1'b1;
            add_expected(r);
        endfunction

        function void note_request(kmpq_pkg::t_in_req req);
            int pos;
            int best;
            longint sum;
            kmpq_pkg::t_out_req r;
            kmpq_pkg::t_out_req listed[kmpq_pkg::CAPACITY];
            int rank;
            case (req.mode)
                kmpq_pkg::MODE_INSERT: begin
                    if (find_key(req.entry_key) >= 0) push_status(kmpq_pkg::ST_DUP);
                    else if (count >= kmpq_pkg::CAPACITY) push_status(kmpq_pkg::ST_FULL);
                    else begin
                        keys[count] = req.entry_key;
                        scores[count] = longint'(req.score_value);
                        count++;
                        push_status(kmpq_pkg::ST_OK);
                    end
                end
                kmpq_pkg::MODE_REMOVE, kmpq_pkg::MODE_ADD: begin
                    pos = find_key(req.entry_key);
                    if (count == 0) push_status(kmpq_pkg::ST_EMPTY);
                    else if (pos < 0) push_status(kmpq_pkg::ST_NOTFOUND);
                    else begin
                        if (req.mode == kmpq_pkg::MODE_REMOVE) begin
                            keys[pos] = keys[count-1];
                            scores[pos] = scores[count-1];
                            count--;
                        end else begin
                            sum = scores[pos] + longint'(req.score_value);
                            if (sum > 64'sd2147483647) sum = 64'sd2147483647;
                            if (sum < -64'sd2147483648) sum = -64'sd2147483648;
                            scores[pos] = sum;
                        end
                        push_status(kmpq_pkg::ST_OK);
                    end
                end
                kmpq_pkg::MODE_TOP: begin
                    if (count == 0) push_status(kmpq_pkg::ST_EMPTY);
                    else begin
                        best = 0;
                        for (int i = 1; i < count; i++) begin
                            if (ahead_of(i, best)) best = i;
                        end
                        r = '0;
                        r.status = kmpq_pkg::ST_OK;
                        r.result_key = keys[best];
                        r.result_score = scores[best][31:0];
                        r.last_of_run = 1'b1;
                        add_expected(r);
                    end
                end
                kmpq_pkg::MODE_LIST: begin
                    if (count == 0) push_status(kmpq_pkg::ST_EMPTY);
                    else begin
                        for (int i = 0; i < count; i++) begin
                            rank = 0;
                            for (int j = 0; j < count; j++) begin
                                if (j != i && ahead_of(j, i)) rank++;
                            end
                            r = '0;
                            r.status = kmpq_pkg::ST_OK;
                            r.result_key = keys[i];
                            r.result_score = scores[i][31:0];
                            r.last_of_run = (rank == count - 1);
                            listed[rank] = r;
                        end
                        for (int i = 0; i < count; i++) add_expected(listed[i]);
                    end
                end
                default: ;
            endcase
        endfunction

        function void check_result(kmpq_pkg::t_out_req got);
            kmpq_pkg::t_out_req want;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %p", got);
                return;
            end
            want = pending.pop_front();
            if (got.status !== want.status || got.result_key !== want.result_key ||
                got.result_score !== want.result_score ||
                got.last_of_run !== want.last_of_run) begin
                mismatches++;
                if (mismatches <= 10) $display("mismatch: expected %p actual %p", want, got);
            end
        endfunction
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_stall;
    kmpq_pkg::t_in_req  i_in_req = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    kmpq_pkg::t_out_req o_out_req;

    queue_scoreboard board = new();
    int  cycle_count = 0;
    bit  hold_off = 1'b0;
    logic [kmpq_pkg::KEY_W-1:0] key_pool[8];

    keyed_max_priority_queue_unit u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_req    (i_in_req),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_req   (o_out_req)
    );

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Check each result taken by the receiver at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) board.check_result(o_out_req);
    end

    // Receiver stall pattern, with a long hold-off when requested
    initial begin
        int phase;
        phase = 0;
        forever begin
            @(negedge i_clk);
            phase++;
            if (hold_off) i_out_stall <= 1'b1;
            else if (phase % 400 < 150) i_out_stall <= 1'b0;
            else i_out_stall <= ($urandom_range(0, 3) == 0);
        end
    end

    // Leaves valid high; the caller sends again or drops it at this falling edge
    task automatic send_request(logic [2:0] mode, logic [kmpq_pkg::KEY_W-1:0] k,
                                logic [31:0] v);
        kmpq_pkg::t_in_req req;
        req.mode = mode;
        req.entry_key = k;
        req.score_value = v;
        i_in_req <= req;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        board.note_request(req);
        @(negedge i_clk);
    endtask

    task automatic send_burst_gap();
        if ($urandom_range(0, 4) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 30)) @(negedge i_clk);
        end
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (board.pending.size() != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
    endtask

    function automatic logic [31:0] random_score();
        case ($urandom_range(0, 5))
            0: return 32'h7fff_ffff;
            1: return 32'h8000_0000;
            2: return $urandom_range(0, 20) - 10;
            default: return $urandom;
        endcase
    endfunction

    initial begin
        int mode_pick;
        logic [2:0] mode;
        logic [kmpq_pkg::KEY_W-1:0] k;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Empty-store cases
        send_request(kmpq_pkg::MODE_TOP, 16'd0, 32'd0);
        send_request(kmpq_pkg::MODE_LIST, 16'd0, 32'd0);
        send_request(kmpq_pkg::MODE_REMOVE, 16'd5, 32'd0);
        send_request(kmpq_pkg::MODE_ADD, 16'd5, 32'd1);
        send_request(3'd5, 16'd1, 32'd0);
        send_request(3'd7, 16'hffff, 32'hffff_ffff);
        // Extremes, duplicate, not found, saturation, equal-score tie
        send_request(kmpq_pkg::MODE_INSERT, 16'hffff, 32'h7fff_ffff);
        send_request(kmpq_pkg::MODE_INSERT, 16'h0000, 32'h8000_0000);
        send_request(kmpq_pkg::MODE_INSERT, 16'hffff, 32'd3);
        send_request(kmpq_pkg::MODE_ADD, 16'hffff, 32'd100);
        send_request(kmpq_pkg::MODE_ADD, 16'h0000, 32'h8000_0000);
        send_request(kmpq_pkg::MODE_INSERT, 16'd7, 32'd9);
        send_request(kmpq_pkg::MODE_INSERT, 16'd3, 32'd9);
        send_request(kmpq_pkg::MODE_ADD, 16'd1234, 32'd1);
        send_request(kmpq_pkg::MODE_REMOVE, 16'd1234, 32'd1);
        send_request(kmpq_pkg::MODE_TOP, 16'd0, 32'd0);
        send_request(kmpq_pkg::MODE_LIST, 16'd0, 32'd0);
        send_request(kmpq_pkg::MODE_REMOVE, 16'hffff, 32'd0);
        send_request(kmpq_pkg::MODE_TOP, 16'd0, 32'd0);
        // Fill to capacity, then overflow
        for (int i = 0; i < kmpq_pkg::CAPACITY; i++) begin
            send_request(kmpq_pkg::MODE_INSERT, 16'(100 + i), random_score());
        end
        send_request(kmpq_pkg::MODE_INSERT, 16'd999, 32'd1);
        send_request(kmpq_pkg::MODE_LIST, 16'd0, 32'd0);
        drain();

        // Long receiver hold-off while requests keep coming
        hold_off = 1'b1;
        fork
            begin
                repeat (600) @(negedge i_clk);
                hold_off = 1'b0;
            end
            for (int i = 0; i < 6; i++) send_request(kmpq_pkg::MODE_TOP, 16'd0, 32'd0);
        join
        drain();
        for (int i = 0; i < kmpq_pkg::CAPACITY; i++) begin
            send_request(kmpq_pkg::MODE_REMOVE, 16'(100 + i), 32'd0);
        end
        send_request(kmpq_pkg::MODE_REMOVE, 16'd7, 32'd0);
        drain();

        // Random traffic, mostly on a small pool of keys
        for (int i = 0; i < 8; i++) key_pool[i] = 16'($urandom);
        for (int n = 0; n < 110; n++) begin
            mode_pick = $urandom_range(0, 99);
            if (mode_pick < 35) mode = kmpq_pkg::MODE_INSERT;
            else if (mode_pick < 50) mode = kmpq_pkg::MODE_REMOVE;
            else if (mode_pick < 72) mode = kmpq_pkg::MODE_ADD;
            else if (mode_pick < 85) mode = kmpq_pkg::MODE_TOP;
            else if (mode_pick < 95) mode = kmpq_pkg::MODE_LIST;
            else mode = 3'($urandom_range(5, 7));
            if ($urandom_range(0, 9) < 8) k = key_pool[$urandom_range(0, 7)];
            else k = 16'($urandom);
            send_request(mode, k, random_score());
            send_burst_gap();
            if (n == 55) drain();
        end
        drain();

        if (board.mismatches == 0 && board.pending.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule
